>>> design/mgi_pkg.sv
`default_nettype none

package mgi_pkg;

  // Register file layout: four axis start registers, then four reciprocal steps.
  localparam int MAX_AXES    = 4;
  localparam int CFG_AXIS_W  = 2;
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_INV_BASE = 3'd4;

  // Item operation codes.
  localparam logic OP_WRITE = 1'b1;

  // Per-axis weights are unsigned Q0.16 with room for exactly one.
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] ONE_Q16 = 17'h10000;

  // Query sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SPLIT,
    ST_CORNER,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Control that travels with each corner through the weighting pipeline.
  typedef struct packed {
    logic                valid;
    logic                first;
    logic                last;
    logic [MAX_AXES-1:0] corner;
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> design/mgi_corner_mac.sv
`default_nettype none

module mgi_corner_mac
  import mgi_pkg::*;
#(
  parameter int RANK = 3,
  parameter int SBW  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mac_ctl_t                     ctl,
  input  wire logic [RANK-1:0][FRAC_W-1:0]  frac,
  input  wire logic [SBW-1:0]               rdata,
  output logic                              done,
  output logic [31:0]                       result
);

  // Weight product of all axes fits 16*RANK+1 bits (at most exactly one).
  localparam int WPW  = 16 * RANK + 1;
  localparam int LIMB = 33;
  localparam int NL   = (WPW + LIMB - 1) / LIMB;
  localparam int ACCW = 16 * RANK + 33;
  localparam int PRW  = 32 + LIMB + 1;

  function automatic logic [FRAC_W-1:0] weight_f(input logic [FRAC_W-1:0] f,
                                                 input logic hi);
    return hi ? f : ONE_Q16 - f;
  endfunction

  mac_ctl_t                   ctl_r [RANK];
  logic [WPW-1:0]             wp_r  [RANK];
  logic signed [31:0]         val_r [1:RANK-1];
  mac_ctl_t                   ctl_p_r;
  logic signed [PRW-1:0]      prod_r [NL];
  logic [NL*LIMB-1:0]         wpad;
  mac_ctl_t                   ctl_t_r;
  logic signed [ACCW-1:0]     term_nxt;
  logic signed [ACCW-1:0]     term_r;
  logic signed [ACCW-1:0]     acc_r;
  logic                       done_r;

  // Stage 0: corner enters, weight of axis 0; the table read lands alongside.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    wp_r[0] <= WPW'(weight_f(frac[0], ctl.corner[0]));
  end

  // Stages 1..RANK-1: fold in one more axis weight per stage.
  for (genvar k = 1; k < RANK; k++) begin : g_wstage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      wp_r[k] <= WPW'(wp_r[k-1] * WPW'(weight_f(frac[k], ctl_r[k-1].corner[k])));
    end

    if (k == 1) begin : g_capture
      always_ff @(posedge clk) begin
        val_r[k] <= 32'(signed'(rdata));
      end
    end else begin : g_carry
      always_ff @(posedge clk) begin
        val_r[k] <= val_r[k-1];
      end
    end
  end

  // Value times weight product, split into 33-bit limbs of the weight.
  assign wpad = (NL*LIMB)'(wp_r[RANK-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_p_r <= '0;
    end else begin
      ctl_p_r <= ctl_r[RANK-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NL; k++) begin
      prod_r[k] <= val_r[RANK-1] * $signed({1'b0, wpad[k*LIMB +: LIMB]});
    end
  end

  // Recombine the limb products into one signed term.
  always_comb begin
    term_nxt = '0;
    for (int k = 0; k < NL; k++) begin
      term_nxt = term_nxt + (ACCW'(prod_r[k]) <<< (LIMB * k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_t_r <= '0;
    end else begin
      ctl_t_r <= ctl_p_r;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
  end

  // Exact accumulation; the first corner of a query restarts the sum.
  always_ff @(posedge clk) begin
    if (ctl_t_r.valid) begin
      acc_r <= ctl_t_r.first ? term_r : acc_r + term_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= ctl_t_r.valid && ctl_t_r.last;
    end
  end

  // Floor to Q16.16 by dropping the weight fraction bits.
  assign done   = done_r;
  assign result = acc_r[16*RANK +: 32];

endmodule

`default_nettype wire

>>> design/multilinear_grid_interpolator.sv
// Write beat: written to the table when accepted; a new beat is taken in the next cycle.
// Query beat: a setup walk over the axes, a split state and 2**RANK corner reads on the
// single table port, then drain through the weighting pipeline and output load; no new
// beat is taken while a query is in progress, and the next one can be taken in the same
// cycle the result becomes valid; a result held by the consumer stalls both.
// Reset restores axis starts to 0 and reciprocal steps to 1.0; table entries are undefined.
`default_nettype none

module multilinear_grid_interpolator
  import mgi_pkg::*;
#(
  parameter int RANK            = 3,
  parameter int POINTS_PER_AXIS = 16,
  parameter int VALUE_WIDTH     = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_operation,
  input  wire logic signed [31:0]     in_coord_0,
  input  wire logic signed [31:0]     in_coord_1,
  input  wire logic signed [31:0]     in_coord_2,
  input  wire logic signed [31:0]     in_coord_3,
  input  wire logic [3:0]             in_write_index_0,
  input  wire logic [3:0]             in_write_index_1,
  input  wire logic [3:0]             in_write_index_2,
  input  wire logic [3:0]             in_write_index_3,
  input  wire logic signed [31:0]     in_write_value,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [31:0]          out_interpolated_value,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);

  function automatic longint unsigned stride_f(input int j);
    longint unsigned s;
    s = 1;
    for (int i = 0; i < j; i++) begin
      s = s * longint'(POINTS_PER_AXIS);
    end
    return s;
  endfunction

  localparam longint unsigned DEPTH = stride_f(RANK);
  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(POINTS_PER_AXIS);
  localparam int AXW  = $clog2(RANK);
  localparam int SBW  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic [AW-1:0] P_AW = AW'(POINTS_PER_AXIS);

  function automatic logic [AW-1:0] offset_f(input logic [RANK-1:0] c);
    logic [AW-1:0] a;
    a = '0;
    for (int j = 0; j < RANK; j++) begin
      if (c[j]) begin
        a = a + AW'(stride_f(j));
      end
    end
    return a;
  endfunction

  state_t                      state_r, state_nxt;
  logic                        in_acc;
  logic                        op_write;
  logic                        setup_en;
  logic                        issue;
  logic                        out_load;

  logic signed [31:0]          low_r [MAX_AXES];
  logic [31:0]                 inv_r [MAX_AXES];

  logic signed [31:0]          in_coord [MAX_AXES];
  logic [3:0]                  in_wix   [MAX_AXES];
  logic signed [31:0]          coord_r  [RANK];

  logic [AXW-1:0]              ax_r;
  logic signed [31:0]          coord_sel;
  logic signed [31:0]          low_sel;
  logic [31:0]                 inv_sel;
  logic [32:0]                 diff;
  logic                        diff_pos;
  logic [63:0]                 prod_nxt;
  logic [63:0]                 prod_r;
  logic                        mv_r;
  logic [AXW-1:0]              max_r;

  logic [CW-1:0]               cell_nxt;
  logic [FRAC_W-1:0]           frac_nxt;
  logic [RANK-1:0][FRAC_W-1:0] frac_r;
  logic [AW-1:0]               base_r;

  logic [RANK-1:0]             cor_r;
  logic                        cor_last;

  logic [AW-1:0]               waddr;
  logic                        w_ok;
  logic                        mem_we;
  logic [AW-1:0]               mem_addr;
  logic [SBW-1:0]              grid_mem [DEPTH];
  logic [SBW-1:0]              rdata_r;

  mac_ctl_t                    mac_ctl;
  logic                        mac_done;
  logic [31:0]                 mac_result;

  logic                        out_valid_r;
  logic signed [31:0]          out_value_r;

  assign in_acc   = in_valid && in_ready;
  assign op_write = (in_operation == OP_WRITE);
  assign cor_last = (cor_r == '1);

  // Next state of the query sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && !op_write) state_nxt = ST_SETUP;
      ST_SETUP:  if (ax_r == '0) state_nxt = ST_SPLIT;
      ST_SPLIT:  state_nxt = ST_CORNER;
      ST_CORNER: if (cor_last) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (mac_done) state_nxt = ST_FINISH;
      ST_FINISH: if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    setup_en = (state_r == ST_SETUP);
    issue    = (state_r == ST_CORNER);
    out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_AXES; j++) begin
        low_r[j] <= '0;
        inv_r[j] <= 32'(ONE_Q16);
      end
    end else if (cfg_we) begin
      if (cfg_index < CFG_INV_BASE) begin
        low_r[cfg_index[CFG_AXIS_W-1:0]] <= cfg_data;
      end else begin
        inv_r[cfg_index[CFG_AXIS_W-1:0]] <= cfg_data;
      end
    end
  end

  // Input beat fields gathered per axis.
  always_comb begin
    in_coord[0] = in_coord_0;
    in_coord[1] = in_coord_1;
    in_coord[2] = in_coord_2;
    in_coord[3] = in_coord_3;
    in_wix[0]   = in_write_index_0;
    in_wix[1]   = in_write_index_1;
    in_wix[2]   = in_write_index_2;
    in_wix[3]   = in_write_index_3;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int j = 0; j < RANK; j++) begin
        coord_r[j] <= in_coord[j];
      end
    end
  end

  // Axis walk runs from the top axis down so the base address builds by Horner.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ax_r <= AXW'(RANK - 1);
    end else if (setup_en) begin
      ax_r <= ax_r - 1'b1;
    end
  end

  // Map one coordinate onto the grid: (coord - low) * inv_step, zero below start.
  always_comb begin
    coord_sel = coord_r[ax_r];
    low_sel   = low_r[CFG_AXIS_W'(ax_r)];
    inv_sel   = inv_r[CFG_AXIS_W'(ax_r)];
    diff      = {coord_sel[31], coord_sel} - {low_sel[31], low_sel};
    diff_pos  = !diff[32] && (diff != '0);
    prod_nxt  = diff_pos ? 64'(diff[31:0]) * 64'(inv_sel) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else begin
      mv_r <= setup_en;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    max_r  <= ax_r;
  end

  // Clamp to the last cell; at or past the top point the fraction is exactly one.
  always_comb begin
    if (prod_r[63:32] >= 32'(POINTS_PER_AXIS - 1)) begin
      cell_nxt = CW'(POINTS_PER_AXIS - 2);
      frac_nxt = ONE_Q16;
    end else begin
      cell_nxt = prod_r[32 +: CW];
      frac_nxt = {1'b0, prod_r[31:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      base_r <= '0;
    end else if (mv_r) begin
      base_r         <= AW'(base_r * P_AW) + AW'(cell_nxt);
      frac_r[max_r]  <= frac_nxt;
    end
  end

  // Corner counter: one table read per cycle.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cor_r <= '0;
    end else if (issue) begin
      cor_r <= cor_r + 1'b1;
    end
  end

  // Write address; a write with an index beyond the grid is dropped.
  always_comb begin
    waddr = '0;
    w_ok  = 1'b1;
    for (int j = 0; j < RANK; j++) begin
      waddr = waddr + AW'(stride_f(j)) * AW'(in_wix[j]);
      if (int'(in_wix[j]) >= POINTS_PER_AXIS) begin
        w_ok = 1'b0;
      end
    end
  end

  assign mem_we   = in_acc && op_write && w_ok;
  assign mem_addr = mem_we ? waddr : base_r + offset_f(cor_r);

  // Single-port grid table with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[mem_addr] <= in_write_value[SBW-1:0];
    end
    rdata_r <= grid_mem[mem_addr];
  end

  always_comb begin
    mac_ctl.valid  = issue;
    mac_ctl.first  = (cor_r == '0);
    mac_ctl.last   = cor_last;
    mac_ctl.corner = MAX_AXES'(cor_r);
  end

  mgi_corner_mac #(
    .RANK (RANK),
    .SBW  (SBW)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .frac   (frac_r),
    .rdata  (rdata_r),
    .done   (mac_done),
    .result (mac_result)
  );

  // Output register: holds a finished result until the consumer takes the beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= mac_result;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_interpolated_value = out_value_r;

endmodule

`default_nettype wire
